### design/midi_parser_timed_queue_core_defines.svh
// Assertion macros for the MIDI parser timed queue core.
// Each takes a label and is used inside a module with clk_i and rst_ni.
`ifndef MIDI_PARSER_TIMED_QUEUE_CORE_DEFINES_SVH
`define MIDI_PARSER_TIMED_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MPTQ_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("mptq: forbidden condition seen");
`define MPTQ_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mptq: implication failed");
`else
`define MPTQ_NEVER(lbl, expr)
`define MPTQ_IMPLY(lbl, ante, cons)
`endif

`endif

### design/mptq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mptq_pkg
// Shared types, codes and defaults of the MIDI parser timed queue core.
// ----------------------------------------------------------------------------
package mptq_pkg;

  localparam int QUEUE_DEPTH_DEF = 128;
  localparam int CHANNELS_DEF    = 16;
  localparam int FINE_PAIRS_DEF  = 32;
  localparam int CMDQ_DEPTH      = 2;

  localparam logic [30:0] GAP_RESET = 31'd11025;

  // request codes (tuser of the input)
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_ADV  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // MIDI status nibbles
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_POLY_AT  = 4'hA;
  localparam logic [3:0] NIB_CTRL     = 4'hB;
  localparam logic [3:0] NIB_PROG     = 4'hC;

  localparam logic [31:0] TTN_EMPTY = 32'h7FFF_FFFF;

  typedef enum logic [3:0] {
    ST_NONE     = 4'd0,
    ST_ENQ      = 4'd1,
    ST_LATE     = 4'd2,
    ST_ORDER    = 4'd3,
    ST_FULL     = 4'd4,
    ST_READ_OK  = 4'd5,
    ST_EMPTY    = 4'd6,
    ST_NOT_DUE  = 4'd7,
    ST_ADVANCED = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    CMD_NULL     = 3'd0,
    CMD_NOTE_ON  = 3'd1,
    CMD_NOTE_OFF = 3'd2,
    CMD_AFTER    = 3'd3,
    CMD_CTRL     = 3'd4,
    CMD_PROG     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    K_NONE,
    K_ENQ,
    K_ADV,
    K_READ
  } kind_e;

  typedef enum logic [1:0] {
    F_CLEAR,
    F_IDLE,
    F_FINE
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_ADV_RD,
    B_ADV_CHK,
    B_LOOK,
    B_WAIT
  } back_state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  ch;
    logic [6:0]  key;
    logic [14:0] val;
    logic [31:0] tstamp;
  } ent_t;

  typedef struct packed {
    kind_e       kind;
    ent_t        ent;
    logic [30:0] delta;
  } bcmd_t;

  typedef struct packed {
    status_e     status;
    ent_t        ent;
    logic [6:0]  skipped;
    logic [6:0]  used;
    logic [31:0] ttn;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cmdq_stat_t;

  // two 7-bit halves joined into 15 bits, msb[6] repeated as the lowest bit
  function automatic logic [14:0] merge15(input logic [6:0] msb, input logic [6:0] lsb);
    merge15 = {msb, lsb, msb[6]};
  endfunction

endpackage
`default_nettype wire

### design/midi_parser_timed_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_parser_timed_queue_core
// MIDI channel message parser feeding a timed ring queue.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_axis    in   tuser req_type, tdata byte/time/delta, tlast buffer_end
//  m_axis    out  tuser status, tdata message and queue fields
//  apb       cfg  reg 0 order_forget_gap at byte address 0
//
// A word passes the parser, then the queue engine states idle, execute,
// look and wait; a fine controller adds a coarse store read in the parser.
// An advance runs a queue memory read, then compare, for each skipped entry
// and once more to finish, in place of execute. After reset the coarse
// store is cleared (CHANNELS*FINE_PAIRS entries) while s_axis_tready stays low.
// A stalled m_axis holds one result; the parser keeps taking words until
// the two-entry command queue fills.
// ----------------------------------------------------------------------------
`include "midi_parser_timed_queue_core_defines.svh"

module midi_parser_timed_queue_core #(
  parameter int QUEUE_DEPTH = mptq_pkg::QUEUE_DEPTH_DEF,
  parameter int CHANNELS    = mptq_pkg::CHANNELS_DEF,
  parameter int FINE_PAIRS  = mptq_pkg::FINE_PAIRS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [71:0]   s_axis_tdata,  // midi_byte, byte_time, time_delta, pad
  input  wire logic [1:0]    s_axis_tuser,  // req_type
  input  wire logic          s_axis_tlast,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [111:0]       m_axis_tdata,  // command, channel, key, value, msg_time,
                                            // skipped_count, queue_used, time_to_next, pad
  output logic [3:0]         m_axis_tuser,  // status
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mptq_pkg::*;

  logic [30:0]  gap_q;
  logic         push, pop;
  bcmd_t        push_cmd, head_cmd;
  cmdq_stat_t   q_stat;
  front_stat_t  f_stat;
  res_t         res;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {1'b0, gap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= GAP_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      gap_q <= pwdata[30:0];
    end
  end

  mptq_front #(
    .CHANNELS   (CHANNELS),
    .FINE_PAIRS (FINE_PAIRS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .req_i      (s_axis_tuser),
    .byte_i     (s_axis_tdata[7:0]),
    .btime_i    (s_axis_tdata[39:8]),
    .bend_i     (s_axis_tlast),
    .delta_i    (s_axis_tdata[70:40]),
    .q_full_i   (q_stat.full),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .stat_o     (f_stat)
  );

  mptq_cmdq u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .stat_o     (q_stat)
  );

  mptq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gap_i       (gap_q),
    .cmd_i       (head_cmd),
    .cmd_avail_i (!q_stat.empty),
    .cmd_pop_o   (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {5'd0, res.ttn, res.used, res.skipped, res.ent.tstamp,
                         res.ent.val, res.ent.key, res.ent.ch, res.ent.cmd};

  `MPTQ_IMPLY(a_clear_blocks_input, f_stat.clearing, !s_axis_tready)
  `MPTQ_NEVER(a_cmdq_full_and_empty, q_stat.full && q_stat.empty)
  `MPTQ_NEVER(a_push_into_full, push && q_stat.full)

endmodule
`default_nettype wire

### design/mptq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mptq_front
// Byte parser: collects channel messages, holds coarse controllers and
// hands one command per accepted word to the back end.
// ----------------------------------------------------------------------------
module mptq_front #(
  parameter int CHANNELS   = mptq_pkg::CHANNELS_DEF,
  parameter int FINE_PAIRS = mptq_pkg::FINE_PAIRS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           req_i,
  input  wire logic [7:0]           byte_i,
  input  wire logic [31:0]          btime_i,
  input  wire logic                 bend_i,
  input  wire logic [30:0]          delta_i,
  input  wire logic                 q_full_i,
  output logic                      push_o,
  output mptq_pkg::bcmd_t           push_cmd_o,
  output mptq_pkg::front_stat_t     stat_o
);
  import mptq_pkg::*;

  localparam int PN = CHANNELS * FINE_PAIRS;
  localparam int PW = (PN > 1) ? $clog2(PN) : 1;

  front_state_e state_q, state_d;
  logic [7:0]    open_q, open_d;
  logic          dc_q, dc_d;
  logic [6:0]    first_q, first_d;
  logic [PW-1:0] clr_q, clr_d;
  ent_t          fent_q, fent_d;

  logic [7:0]    pend_mem [PN];
  logic [7:0]    pend_rdata_q;
  logic          pend_we, pend_re;
  logic [PW-1:0] pend_wa, pend_ra;
  logic [7:0]    pend_wd;

  logic          acc, need_fine;
  logic [3:0]    hi, ohi;
  logic [3:0]    ch;
  logic          ch_ok;
  logic [7:0]    d1x;
  logic [6:0]    fine_idx;

  assign in_ready_o = (state_q == F_IDLE) && !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign hi         = byte_i[7:4];
  assign ohi        = open_q[7:4];
  assign ch         = open_q[3:0];
  assign ch_ok      = {1'b0, ch} < 5'(CHANNELS);
  assign d1x        = {1'b0, first_q};
  assign fine_idx   = first_q - 7'(FINE_PAIRS);

  always_comb begin
    open_d     = open_q;
    dc_d       = dc_q;
    first_d    = first_q;
    clr_d      = clr_q;
    fent_d     = fent_q;
    push_o     = 1'b0;
    push_cmd_o = '0;
    pend_we    = 1'b0;
    pend_wa    = clr_q;
    pend_wd    = '0;
    pend_re    = 1'b0;
    pend_ra    = '0;
    need_fine  = 1'b0;
    unique case (state_q)
      F_CLEAR: begin
        pend_we = 1'b1;
        clr_d   = clr_q + 1'b1;
      end
      F_IDLE: begin
        if (acc) begin
          push_o = 1'b1;
          case (req_i)
            REQ_BYTE: begin
              if (byte_i[7]) begin
                open_d = ((hi == NIB_NOTE_OFF || hi == NIB_NOTE_ON || hi == NIB_POLY_AT ||
                           hi == NIB_CTRL || hi == NIB_PROG) && !bend_i) ? byte_i : 8'd0;
                dc_d   = 1'b0;
              end else if (open_q != 8'd0) begin
                push_cmd_o.ent.ch     = ch;
                push_cmd_o.ent.tstamp = btime_i;
                if (ohi == NIB_PROG) begin
                  push_cmd_o.kind    = K_ENQ;
                  push_cmd_o.ent.cmd = CMD_PROG;
                  push_cmd_o.ent.key = byte_i[6:0];
                  open_d = 8'd0;
                  dc_d   = 1'b0;
                end else if (!dc_q) begin
                  push_cmd_o = '0;
                  first_d = byte_i[6:0];
                  dc_d    = 1'b1;
                  if (bend_i) begin
                    open_d = 8'd0;
                    dc_d   = 1'b0;
                  end
                end else begin
                  open_d = 8'd0;
                  dc_d   = 1'b0;
                  push_cmd_o.ent.key = first_q;
                  push_cmd_o.ent.val = {8'd0, byte_i[6:0]};
                  push_cmd_o.kind    = K_ENQ;
                  unique case (ohi)
                    NIB_NOTE_ON:  push_cmd_o.ent.cmd = (byte_i[6:0] != 7'd0) ?
                                                       CMD_NOTE_ON : CMD_NOTE_OFF;
                    NIB_NOTE_OFF: push_cmd_o.ent.cmd = CMD_NOTE_OFF;
                    NIB_POLY_AT:  push_cmd_o.ent.cmd = CMD_AFTER;
                    default: begin
                      push_cmd_o.ent.cmd = CMD_CTRL;
                      if (d1x < 8'(FINE_PAIRS)) begin
                        // coarse half: park it, no message yet
                        push_cmd_o = '0;
                        pend_we = ch_ok;
                        pend_wa = PW'(int'(ch) * FINE_PAIRS + int'(first_q));
                        pend_wd = {1'b1, byte_i[6:0]};
                      end else if (d1x < 8'(2 * FINE_PAIRS)) begin
                        if (ch_ok) begin
                          push_o    = 1'b0;
                          need_fine = 1'b1;
                          fent_d    = push_cmd_o.ent;
                          pend_re   = 1'b1;
                          pend_ra   = PW'(int'(ch) * FINE_PAIRS + int'(fine_idx));
                        end else begin
                          push_cmd_o = '0;
                        end
                      end else begin
                        push_cmd_o.ent.val = merge15(byte_i[6:0], byte_i[6:0]);
                      end
                    end
                  endcase
                end
              end
            end
            REQ_ADV: begin
              push_cmd_o.kind  = K_ADV;
              push_cmd_o.delta = delta_i;
            end
            REQ_READ: push_cmd_o.kind = K_READ;
            default: push_cmd_o = '0;
          endcase
        end
      end
      F_FINE: begin
        push_o = 1'b1;
        if (pend_rdata_q[7]) begin
          push_cmd_o.kind    = K_ENQ;
          push_cmd_o.ent     = fent_q;
          push_cmd_o.ent.val = merge15(pend_rdata_q[6:0], fent_q.val[6:0]);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_CLEAR: if (clr_q == PW'(PN - 1)) state_d = F_IDLE;
      F_IDLE:  if (need_fine) state_d = F_FINE;
      F_FINE:  state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_CLEAR;
      open_q  <= '0;
      dc_q    <= 1'b0;
      first_q <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      dc_q    <= dc_d;
      first_q <= first_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fent_q <= fent_d;
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    if (pend_re) pend_rdata_q <= pend_mem[pend_ra];
  end

  assign stat_o.clearing = (state_q == F_CLEAR);
  assign stat_o.busy     = (state_q == F_FINE);

endmodule
`default_nettype wire

### design/mptq_cmdq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mptq_cmdq
// Two-entry command queue between the parser and the queue engine.
// ----------------------------------------------------------------------------
module mptq_cmdq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  mptq_pkg::bcmd_t       push_cmd_i,
  input  wire logic             pop_i,
  output mptq_pkg::bcmd_t       head_o,
  output mptq_pkg::cmdq_stat_t  stat_o
);
  import mptq_pkg::*;

  localparam int CW = $clog2(CMDQ_DEPTH);

  bcmd_t         slot_q [CMDQ_DEPTH];
  logic [CW-1:0] rp_q, wp_q;
  logic [CW:0]   cnt_q;
  logic          do_push, do_pop;

  assign stat_o.full  = (cnt_q == (CW + 1)'(CMDQ_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (CW + 1)'(do_push) - (CW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wp_q] <= push_cmd_i;
  end

endmodule
`default_nettype wire

### design/mptq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mptq_back
// Timed ring queue engine: enqueue with late/order/full checks, advance
// with skip drain, read of the due entry, and the result register.
// ----------------------------------------------------------------------------
module mptq_back #(
  parameter int QUEUE_DEPTH = mptq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [30:0]   gap_i,
  input  mptq_pkg::bcmd_t    cmd_i,
  input  wire logic          cmd_avail_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mptq_pkg::res_t     out_o
);
  import mptq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  back_state_e   state_q, state_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [31:0]   play_q, play_d, last_q, last_d;
  bcmd_t         cur_q, cur_d;
  res_t          res_q, res_d, out_q, out_d;
  logic          ovalid_q, ovalid_d;
  ent_t          tail_ent_q, rdata_q;

  ent_t          mem [QUEUE_DEPTH];
  logic          we, re;
  logic [AW-1:0] ra;

  logic          q_empty;
  logic [AW-1:0] head_nx, tail_nx;
  logic [31:0]   dt_play, dt_last, dt_head, dt_gap;
  logic [AW:0]   used;
  logic [31:0]   used32;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign q_empty   = (head_q == tail_q);
  assign head_nx   = ring_next(head_q);
  assign tail_nx   = ring_next(tail_q);
  assign dt_play   = cur_q.ent.tstamp - play_q;
  assign dt_last   = cur_q.ent.tstamp - last_q;
  assign dt_head   = rdata_q.tstamp - play_q;
  assign dt_gap    = play_d - last_q;
  assign cmd_pop_o = (state_q == B_IDLE) && cmd_avail_i;
  assign used      = (head_q >= tail_q) ? ({1'b0, head_q} - {1'b0, tail_q}) :
                     ({1'b0, head_q} + (AW + 1)'(QUEUE_DEPTH) - {1'b0, tail_q});
  assign used32    = 32'(used);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    play_d   = play_q;
    last_d   = last_q;
    cur_d    = cur_q;
    res_d    = res_q;
    out_d    = out_q;
    ovalid_d = ovalid_q && !out_ready_i;
    we       = 1'b0;
    re       = 1'b0;
    ra       = tail_q;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_avail_i) begin
          cur_d = cmd_i;
          res_d = '0;
        end
      end
      B_EXEC: begin
        case (cur_q.kind)
          K_ENQ: begin
            res_d.ent = cur_q.ent;
            if (dt_play[31]) begin
              res_d.status = ST_LATE;
            end else if (last_q != 32'd0 && dt_last[31]) begin
              res_d.status = ST_ORDER;
            end else if (head_nx == tail_q) begin
              res_d.status = ST_FULL;
            end else begin
              we           = 1'b1;
              head_d       = head_nx;
              last_d       = cur_q.ent.tstamp;
              res_d.status = ST_ENQ;
            end
          end
          K_READ: begin
            res_d.ent.tstamp = play_q;
            if (q_empty) begin
              res_d.status = ST_EMPTY;
            end else if (tail_ent_q.tstamp != play_q) begin
              res_d.status = ST_NOT_DUE;
            end else begin
              res_d.ent    = tail_ent_q;
              res_d.status = ST_READ_OK;
              tail_d       = tail_nx;
            end
          end
          default: res_d.status = ST_NONE;
        endcase
      end
      B_ADV_RD: re = 1'b1;
      B_ADV_CHK: begin
        // drop the head while it falls inside the advance window
        if (!q_empty &&
            ($signed({2'b00, cur_q.delta}) > $signed({dt_head[31], dt_head}))) begin
          tail_d = tail_nx;
          if (res_q.skipped != 7'h7F) res_d.skipped = res_q.skipped + 1'b1;
        end else begin
          play_d = play_q + {1'b0, cur_q.delta};
          if (last_q != 32'd0 && ($signed({dt_gap[31], dt_gap}) > $signed({2'b00, gap_i})))
            last_d = 32'd0;
          res_d.status     = ST_ADVANCED;
          res_d.ent.tstamp = play_d;
        end
      end
      B_LOOK: re = 1'b1;
      B_WAIT: begin
        if (!ovalid_q || out_ready_i) begin
          out_d      = res_q;
          out_d.used = used32[6:0];
          out_d.ttn  = q_empty ? TTN_EMPTY : dt_head;
          ovalid_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:    if (cmd_avail_i) state_d = (cmd_i.kind == K_ADV) ? B_ADV_RD : B_EXEC;
      B_EXEC:    state_d = B_LOOK;
      B_ADV_RD:  state_d = B_ADV_CHK;
      B_ADV_CHK: state_d = (res_d.status == ST_ADVANCED) ? B_LOOK : B_ADV_RD;
      B_LOOK:    state_d = B_WAIT;
      B_WAIT:    if (!ovalid_q || out_ready_i) state_d = B_IDLE;
      default:   state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      play_q   <= '0;
      last_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      play_q   <= play_d;
      last_q   <= last_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
    out_q <= out_d;
    if (state_q == B_WAIT) tail_ent_q <= rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[head_q] <= cur_q.ent;
    if (re) rdata_q <= mem[ra];
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire
